FILE: rtl/blc_pkg.sv
// Shared types and constants for the byte FIFO with line counter.
package blc_pkg;

	// Register indexes on the configuration port.
	localparam int unsigned CFG_IDX_W  = 8;
	localparam int unsigned CFG_DATA_W = 9;
	localparam logic [CFG_IDX_W-1:0] REG_EOL_CHAR  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RING_SIZE = 8'd1;

	// Reset value of the end-of-line byte.
	localparam logic [7:0] EOL_RESET = 8'd10;

	// Request codes.
	typedef enum logic [1:0] {
		REQ_WRITE = 2'd0,
		REQ_READ  = 2'd1,
		REQ_PEEK  = 2'd2,
		REQ_CLEAR = 2'd3
	} req_code_t;

	// One request transaction.
	typedef struct packed {
		req_code_t  req_type;
		logic [7:0] wr_byte;
	} req_t;

	// One response transaction.
	typedef struct packed {
		logic       accepted;
		logic [7:0] rd_byte;
		logic [7:0] fill_count;
		logic [7:0] free_count;
		logic [7:0] line_count;
		logic       is_empty;
		logic       is_full;
	} rsp_t;

endpackage

FILE: rtl/blc_mem.sv
// Byte storage: one write port and one read port with registered read data.
module blc_mem #(
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [7:0]               wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [7:0]               rd_data
);

	logic [7:0] store [DEPTH];
	logic [7:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store[wr_addr] <= wr_data;
		end
	end

	// Read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= store[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/blc_ctrl.sv
// FIFO pointers, fill and line counters, and formation of the response fields.
module blc_ctrl #(
	parameter int unsigned DEPTH = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       take,
	input  blc_pkg::req_t              req,
	input  logic [$clog2(DEPTH+1)-1:0] ring_size,
	input  logic [7:0]                 eol_char,
	input  logic                       flush,
	output blc_pkg::rsp_t              rsp,
	output logic                       mem_wr_en,
	output logic [$clog2(DEPTH)-1:0]   mem_wr_addr,
	output logic [7:0]                 mem_wr_data,
	output logic                       mem_rd_en,
	output logic [$clog2(DEPTH)-1:0]   mem_rd_addr,
	input  logic [7:0]                 mem_rd_data
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned RS_W  = $clog2(DEPTH + 1);

	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [RS_W-1:0]  fill_q;
	logic [7:0]       lines_q;
	logic             pend_q;
	logic             ok_q;
	logic             rd_ok_q;

	logic [RS_W-1:0]  wr_inc;
	logic [RS_W-1:0]  rd_inc;
	logic [PTR_W-1:0] wr_nxt;
	logic [PTR_W-1:0] rd_nxt;
	logic             full;
	logic             empty;
	logic [7:0]       lines_eff;
	logic [PTR_W-1:0] wr_ptr_d;
	logic [PTR_W-1:0] rd_ptr_d;
	logic [RS_W-1:0]  fill_d;
	logic [7:0]       lines_d;
	logic             pend_d;
	logic             ok_d;
	logic             rd_ok_d;
	logic [31:0]      fill_w;
	logic [31:0]      free_w;

	// Next slot of each pointer, wrapping at the ring size.
	always_comb begin
		wr_inc = RS_W'(wr_ptr_q) + RS_W'(1);
		rd_inc = RS_W'(rd_ptr_q) + RS_W'(1);
		wr_nxt = (wr_inc >= ring_size) ? '0 : wr_inc[PTR_W-1:0];
		rd_nxt = (rd_inc >= ring_size) ? '0 : rd_inc[PTR_W-1:0];
		full   = (fill_q == ring_size - RS_W'(1));
		empty  = (fill_q == '0);
	end

	// The byte of the last read comes from the registered read port, so its end-of-line
	// decrement is folded into the line count here.
	always_comb begin
		if (pend_q && (mem_rd_data == eol_char) && (lines_q != 8'd0)) begin
			lines_eff = lines_q - 8'd1;
		end else begin
			lines_eff = lines_q;
		end
	end

	// Request decode and next state.
	always_comb begin
		wr_ptr_d    = wr_ptr_q;
		rd_ptr_d    = rd_ptr_q;
		fill_d      = fill_q;
		lines_d     = lines_eff;
		pend_d      = 1'b0;
		ok_d        = ok_q;
		rd_ok_d     = rd_ok_q;
		mem_wr_en   = 1'b0;
		mem_rd_en   = 1'b0;
		mem_wr_addr = wr_ptr_q;
		mem_wr_data = req.wr_byte;
		mem_rd_addr = rd_ptr_q;
		if (take) begin
			ok_d    = 1'b0;
			rd_ok_d = 1'b0;
			case (req.req_type)
				blc_pkg::REQ_WRITE: begin
					if (!full) begin
						mem_wr_en = 1'b1;
						wr_ptr_d  = wr_nxt;
						fill_d    = fill_q + RS_W'(1);
						ok_d      = 1'b1;
						if ((req.wr_byte == eol_char) && (lines_eff != 8'hFF)) begin
							lines_d = lines_eff + 8'd1;
						end
					end
				end
				blc_pkg::REQ_READ: begin
					if (!empty) begin
						mem_rd_en = 1'b1;
						rd_ptr_d  = rd_nxt;
						fill_d    = fill_q - RS_W'(1);
						pend_d    = 1'b1;
						ok_d      = 1'b1;
						rd_ok_d   = 1'b1;
					end
				end
				blc_pkg::REQ_PEEK: begin
					if (!empty) begin
						mem_rd_en = 1'b1;
						ok_d      = 1'b1;
						rd_ok_d   = 1'b1;
					end
				end
				blc_pkg::REQ_CLEAR: begin
					rd_ptr_d = wr_ptr_q;
					fill_d   = '0;
					lines_d  = 8'd0;
					ok_d     = 1'b1;
				end
				default: begin
					ok_d = 1'b0;
				end
			endcase
		end
	end

	// State registers; a ring size write empties the FIFO.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
			lines_q  <= 8'd0;
			pend_q   <= 1'b0;
			ok_q     <= 1'b0;
			rd_ok_q  <= 1'b0;
		end else if (flush) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
			lines_q  <= 8'd0;
			pend_q   <= 1'b0;
		end else begin
			wr_ptr_q <= wr_ptr_d;
			rd_ptr_q <= rd_ptr_d;
			fill_q   <= fill_d;
			lines_q  <= lines_d;
			pend_q   <= pend_d;
			ok_q     <= ok_d;
			rd_ok_q  <= rd_ok_d;
		end
	end

	// Response fields, with counts saturated to eight bits.
	always_comb begin
		fill_w              = 32'(fill_q);
		free_w              = 32'(ring_size) - 32'd1 - fill_w;
		rsp.accepted        = ok_q;
		rsp.rd_byte         = rd_ok_q ? mem_rd_data : 8'd0;
		rsp.fill_count      = (fill_w > 32'd255) ? 8'hFF : fill_w[7:0];
		rsp.free_count      = (free_w > 32'd255) ? 8'hFF : free_w[7:0];
		rsp.line_count      = lines_eff;
		rsp.is_empty        = (fill_w == 32'd0);
		rsp.is_full         = (free_w == 32'd0);
	end

endmodule

FILE: rtl/byte_fifo_with_line_count.sv
// Top level of the byte FIFO with line counter: handshake and configuration registers.
//
// A request transaction on req (write, read, peek or clear) is taken when
// req_valid and req_ready are both high. Its response appears on rsp with
// rsp_valid in the next cycle and stays until rsp_ready takes it. One
// request is taken per clock cycle while the response side keeps up; this
// rate is set by the single registered pass through the pointer logic and
// the read port of the byte store.
// When a response is held because rsp_ready is low, req_ready falls and
// no further request is taken until the held response leaves.
// The ring holds ring_size - 1 bytes at most; ring_size is clamped to the
// range 2 to DEPTH, and writing it empties the FIFO.
// After reset the FIFO is empty, the line count is zero, the end-of-line byte
// is 10 and ring_size is DEPTH or 256, whichever is smaller. The byte store
// itself is not cleared; only written entries are ever read.
// Configuration writes are to be made only while no transaction is in flight.
module byte_fifo_with_line_count #(
	parameter int unsigned DEPTH = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_ready,
	input  blc_pkg::req_t                      req,
	output logic                               rsp_valid,
	input  logic                               rsp_ready,
	output blc_pkg::rsp_t                      rsp,
	input  logic                               cfg_wr_en,
	input  logic [blc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [blc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	localparam int unsigned PTR_W      = $clog2(DEPTH);
	localparam int unsigned RS_W       = $clog2(DEPTH + 1);
	localparam int unsigned RING_RESET = (DEPTH < 256) ? DEPTH : 256;

	logic [7:0]       eol_q;
	logic [RS_W-1:0]  ring_q;
	logic             rsp_valid_q;
	logic             take;
	logic             flush;
	logic [31:0]      ring_w;
	logic [31:0]      ring_clamped;
	logic             mem_wr_en;
	logic [PTR_W-1:0] mem_wr_addr;
	logic [7:0]       mem_wr_data;
	logic             mem_rd_en;
	logic [PTR_W-1:0] mem_rd_addr;
	logic [7:0]       mem_rd_data;

	// Handshake: a new request is taken when the response slot is free or
	// being emptied in this cycle.
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign take      = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Ring size clamped into the legal range.
	always_comb begin
		ring_w = 32'(cfg_wdata);
		if (ring_w < 32'd2) begin
			ring_clamped = 32'd2;
		end else if (ring_w > 32'(DEPTH)) begin
			ring_clamped = 32'(DEPTH);
		end else begin
			ring_clamped = ring_w;
		end
	end

	assign flush = cfg_wr_en && (cfg_index == blc_pkg::REG_RING_SIZE);

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eol_q  <= blc_pkg::EOL_RESET;
			ring_q <= RS_W'(RING_RESET);
		end else if (cfg_wr_en) begin
			if (cfg_index == blc_pkg::REG_EOL_CHAR) begin
				eol_q <= cfg_wdata[7:0];
			end
			if (cfg_index == blc_pkg::REG_RING_SIZE) begin
				ring_q <= ring_clamped[RS_W-1:0];
			end
		end
	end

	// FIFO control and response formation.
	blc_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.req        (req),
		.ring_size  (ring_q),
		.eol_char   (eol_q),
		.flush      (flush),
		.rsp        (rsp),
		.mem_wr_en  (mem_wr_en),
		.mem_wr_addr(mem_wr_addr),
		.mem_wr_data(mem_wr_data),
		.mem_rd_en  (mem_rd_en),
		.mem_rd_addr(mem_rd_addr),
		.mem_rd_data(mem_rd_data)
	);

	// Byte store.
	blc_mem #(
		.DEPTH(DEPTH)
	) u_mem (
		.clk    (clk),
		.wr_en  (mem_wr_en),
		.wr_addr(mem_wr_addr),
		.wr_data(mem_wr_data),
		.rd_en  (mem_rd_en),
		.rd_addr(mem_rd_addr),
		.rd_data(mem_rd_data)
	);

endmodule

FILE: tb/tb_byte_fifo_with_line_count.sv
// Self-checking testbench for the byte FIFO with line counter, using random traffic and stalls.
module tb_byte_fifo_with_line_count;
	import blc_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned RANDOM_PHASES = 10;
	localparam int unsigned PHASE_ITEMS = 16;
	localparam int unsigned LONG_HOLD = 80;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'hFF;
	localparam logic [8:0] RING_PLAN [RANDOM_PHASES] = '{
		9'd1, 9'd3, 9'd17, 9'd256, 9'd5, 9'd300, 9'd64, 9'd2, 9'd9, 9'd33
	};

	// How a side spaces its transactions.
	typedef enum int {
		IDLE_NONE,
		IDLE_UNIFORM,
		IDLE_SPARSE
	} idle_mode_t;

	// Shadow copy of the FIFO that predicts each response and checks it on arrival.
	class line_fifo_shadow;
		logic [7:0] slot_bytes [256];
		int unsigned wr_pos = 0;
		int unsigned rd_pos = 0;
		int unsigned lines = 0;
		int unsigned ring = 256;
		logic [7:0] eol = EOL_RESET;
		rsp_t due_rsp [$];
		int unsigned mismatches = 0;
		int unsigned responses = 0;
		int unsigned refused = 0;
		int unsigned full_seen = 0;
		int unsigned peak_lines = 0;
		int unsigned settings = 0;

		function int unsigned pending();
			return due_rsp.size();
		endfunction

		function int unsigned advance(int unsigned pos);
			return (pos + 1 >= ring) ? 0 : pos + 1;
		endfunction

		// A ring size write is clamped to the legal range and empties the FIFO.
		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
			REG_EOL_CHAR: begin
				eol = data[7:0];
			end
			REG_RING_SIZE: begin
				ring = (data < 9'd2) ? 2 : (data > 9'd256) ? 256 : int'(data);
				wr_pos = 0;
				rd_pos = 0;
				lines = 0;
			end
			default: ;
			endcase
			settings++;
		endfunction

		// Works out the response to one accepted request transaction.
		function void note_request(req_t r);
			rsp_t want;
			int unsigned nxt;
			int unsigned fill;
			int unsigned room;
			want = '0;
			case (r.req_type)
			REQ_WRITE: begin
				nxt = advance(wr_pos);
				if (nxt != rd_pos) begin
					slot_bytes[wr_pos] = r.wr_byte;
					wr_pos = nxt;
					if (r.wr_byte == eol && lines < 255)
						lines++;
					want.accepted = 1'b1;
				end
			end
			REQ_READ, REQ_PEEK: begin
				if (rd_pos != wr_pos) begin
					want.rd_byte = slot_bytes[rd_pos];
					want.accepted = 1'b1;
					if (r.req_type == REQ_READ) begin
						rd_pos = advance(rd_pos);
						if (want.rd_byte == eol && lines > 0)
							lines--;
					end
				end
			end
			default: begin
				rd_pos = wr_pos;
				lines = 0;
				want.accepted = 1'b1;
			end
			endcase
			fill = (wr_pos >= rd_pos) ? wr_pos - rd_pos : wr_pos + ring - rd_pos;
			room = ring - 1 - fill;
			want.fill_count = (fill > 255) ? 8'd255 : fill[7:0];
			want.free_count = (room > 255) ? 8'd255 : room[7:0];
			want.line_count = (lines > 255) ? 8'd255 : lines[7:0];
			want.is_empty = (fill == 0);
			want.is_full = (room == 0);
			due_rsp.push_back(want);
		endfunction

		function void report(string field, logic [7:0] want, logic [7:0] got);
			mismatches++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
		endfunction

		// Compares a response transaction with the oldest prediction, field by field.
		function void check_response(rsp_t got);
			rsp_t want;
			if (due_rsp.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected response, expected none, actual %h", $time, got);
				return;
			end
			want = due_rsp.pop_front();
			responses++;
			if (got.accepted !== want.accepted)
				report("accepted", want.accepted, got.accepted);
			if (got.rd_byte !== want.rd_byte)
				report("rd_byte", want.rd_byte, got.rd_byte);
			if (got.fill_count !== want.fill_count)
				report("fill_count", want.fill_count, got.fill_count);
			if (got.free_count !== want.free_count)
				report("free_count", want.free_count, got.free_count);
			if (got.line_count !== want.line_count)
				report("line_count", want.line_count, got.line_count);
			if (got.is_empty !== want.is_empty)
				report("is_empty", want.is_empty, got.is_empty);
			if (got.is_full !== want.is_full)
				report("is_full", want.is_full, got.is_full);
			if (!want.accepted)
				refused++;
			if (want.is_full)
				full_seen++;
			if (want.line_count > peak_lines)
				peak_lines = want.line_count;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	line_fifo_shadow shadow = new();
	idle_mode_t send_idle_mode = IDLE_UNIFORM;
	idle_mode_t take_idle_mode = IDLE_SPARSE;
	int rsp_hold_cycles = 0;
	int unsigned cycles = 0;

	byte_fifo_with_line_count dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// The run is abandoned if it goes on far longer than the slowest correct run.
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timed out after %0d cycles, %0d responses outstanding.", cycles,
			shadow.pending());
		$display("FAIL byte_fifo_with_line_count");
		$finish;
	end

	function automatic int draw_gap(idle_mode_t mode);
		case (mode)
		IDLE_NONE: return 0;
		IDLE_UNIFORM: return $urandom_range(0, 15);
		default: return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 15) : 0;
		endcase
	endfunction

	// Response side: stalls at random, or for a long stretch when asked, then checks.
	initial begin
		int gap;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (rsp_hold_cycles > 0) begin
				gap = rsp_hold_cycles;
				rsp_hold_cycles = 0;
			end else begin
				gap = draw_gap(take_idle_mode);
			end
			if (gap > 0) begin
				rsp_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			@(posedge clk);
			while (!rsp_valid)
				@(posedge clk);
			shadow.check_response(rsp);
		end
	end

	// Offers one request transaction after a random gap and waits for it to be taken.
	task automatic push_request(req_code_t op, logic [7:0] data);
		req_t r;
		int gap;
		r.req_type = op;
		r.wr_byte = data;
		gap = draw_gap(send_idle_mode);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		shadow.note_request(r);
	endtask

	task automatic pause_requests();
		req_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_for_responses();
		while (shadow.pending() != 0)
			@(posedge clk);
	endtask

	// Register writes are only made with nothing in flight.
	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_index <= idx;
		cfg_wdata <= data;
		cfg_wr_en <= 1'b1;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		shadow.set_register(idx, data);
		@(posedge clk);
	endtask

	initial begin
		logic [7:0] eol_pick;
		logic [7:0] data;
		logic [CFG_IDX_W-1:0] idx_pick;
		req_code_t op;
		int write_pct;
		int sel;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: empty refusals, byte extremes, newline counting and clears.
		push_request(REQ_READ, 8'h00);
		push_request(REQ_PEEK, 8'hFF);
		push_request(REQ_WRITE, EOL_RESET);
		push_request(REQ_WRITE, 8'h00);
		push_request(REQ_WRITE, 8'hFF);
		push_request(REQ_PEEK, 8'h00);
		push_request(REQ_READ, 8'h00);
		push_request(REQ_READ, 8'h00);
		push_request(REQ_CLEAR, 8'h00);
		push_request(REQ_CLEAR, 8'h00);
		push_request(REQ_WRITE, EOL_RESET);
		push_request(REQ_WRITE, EOL_RESET);
		push_request(REQ_CLEAR, 8'h00);
		push_request(REQ_READ, 8'h00);

		// A ring size below the minimum is clamped, leaving room for a single byte.
		pause_requests();
		wait_for_responses();
		write_register(REG_RING_SIZE, 9'd0);
		write_register(REG_EOL_CHAR, 9'h0FF);
		push_request(REQ_WRITE, 8'hFF);
		push_request(REQ_WRITE, 8'h55);
		push_request(REQ_PEEK, 8'h00);
		push_request(REQ_READ, 8'h00);
		push_request(REQ_READ, 8'h00);
		push_request(REQ_WRITE, 8'h00);
		push_request(REQ_CLEAR, 8'h00);

		// Random phases, each with its own settings, mix of requests and idling.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			pause_requests();
			wait_for_responses();
			case ($urandom_range(0, 4))
			0: eol_pick = 8'h00;
			1: eol_pick = 8'hFF;
			2: eol_pick = EOL_RESET;
			default: eol_pick = 8'($urandom_range(0, 255));
			endcase
			write_register(REG_EOL_CHAR, {1'b0, eol_pick});
			if (p % 2 == 0 || $urandom_range(0, 1) == 1)
				write_register(REG_RING_SIZE, RING_PLAN[p]);
			if ($urandom_range(0, 3) == 0) begin
				idx_pick = ($urandom_range(0, 1) == 1) ? REG_UNMAPPED :
					CFG_IDX_W'($urandom_range(2, 254));
				write_register(idx_pick, CFG_DATA_W'($urandom_range(0, 511)));
			end
			send_idle_mode = idle_mode_t'(p % 3);
			take_idle_mode = idle_mode_t'($urandom_range(0, 2));
			write_pct = (p % 3 == 0) ? 80 : (p % 3 == 1) ? 35 : 55;
			// Here the response side stalls for a long time while requests keep coming.
			if (p == 3)
				rsp_hold_cycles = LONG_HOLD;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if ($urandom_range(0, 39) == 0) begin
					pause_requests();
					wait_for_responses();
				end
				if ($urandom_range(0, 99) < write_pct) begin
					op = REQ_WRITE;
				end else begin
					sel = $urandom_range(0, 19);
					op = (sel < 13) ? REQ_READ : (sel < 18) ? REQ_PEEK : REQ_CLEAR;
				end
				case ($urandom_range(0, 3))
				0: data = shadow.eol;
				1: data = 8'($urandom_range(0, 3));
				default: data = 8'($urandom_range(0, 255));
				endcase
				push_request(op, data);
			end
		end

		// Fill the largest ring with line ends, then push the line count past its ceiling.
		pause_requests();
		wait_for_responses();
		send_idle_mode = IDLE_SPARSE;
		take_idle_mode = IDLE_SPARSE;
		write_register(REG_RING_SIZE, 9'h1FF);
		write_register(REG_EOL_CHAR, 9'h041);
		repeat (256) push_request(REQ_WRITE, 8'h41);
		pause_requests();
		wait_for_responses();
		write_register(REG_EOL_CHAR, 9'h042);
		push_request(REQ_READ, 8'h00);
		push_request(REQ_WRITE, 8'h42);
		push_request(REQ_PEEK, 8'h00);
		push_request(REQ_CLEAR, 8'h00);
		repeat (3) push_request(REQ_WRITE, 8'h60);

		// Bytes stored before they became line ends must not take the count below zero.
		pause_requests();
		wait_for_responses();
		write_register(REG_EOL_CHAR, 9'h060);
		repeat (4) push_request(REQ_READ, 8'h00);

		pause_requests();
		wait_for_responses();
		repeat (4) @(posedge clk);
		$display("Checked %0d responses over %0d register writes, ring sizes 2 to 256; %0d refused.",
			shadow.responses, shadow.settings, shadow.refused);
		$display("FIFO seen full %0d times, highest line count %0d, %0d mismatches.",
			shadow.full_seen, shadow.peak_lines, shadow.mismatches);
		if (shadow.mismatches == 0)
			$display("PASS byte_fifo_with_line_count");
		else
			$display("FAIL byte_fifo_with_line_count");
		$finish;
	end

endmodule
